// File: design/pfhc_pkg.sv
// Shared constants and types for the pipelined fetch block.
// No dependencies; imported by the top level and the checker.
`default_nettype none

package pfhc_pkg;

  localparam int MEM_BYTES_DEF = 4096;
  localparam int ROW_BYTES     = 16;

  // Instruction codes
  localparam logic [3:0] OP_HALT  = 4'h0;
  localparam logic [3:0] OP_NOP   = 4'h1;
  localparam logic [3:0] OP_RRMOV = 4'h2;
  localparam logic [3:0] OP_IRMOV = 4'h3;
  localparam logic [3:0] OP_RMMOV = 4'h4;
  localparam logic [3:0] OP_MRMOV = 4'h5;
  localparam logic [3:0] OP_ALU   = 4'h6;
  localparam logic [3:0] OP_JUMP  = 4'h7;
  localparam logic [3:0] OP_CALL  = 4'h8;
  localparam logic [3:0] OP_RET   = 4'h9;
  localparam logic [3:0] OP_PUSH  = 4'hA;
  localparam logic [3:0] OP_POP   = 4'hB;
  localparam logic [3:0] NO_REG   = 4'hF;

  // Item operations
  localparam logic OPER_WRITE = 1'b0;
  localparam logic OPER_FETCH = 1'b1;

  typedef enum logic [1:0] {
    STAT_AOK = 2'd0,
    STAT_HLT = 2'd1,
    STAT_ADR = 2'd2,
    STAT_INS = 2'd3
  } status_e;

endpackage

`default_nettype wire

// File: design/pfhc_in_if.sv
// Input channel of the fetch block: valid/ready handshake plus one item.
// Depends on nothing; used by pipelined_fetch_with_hazard_control.
`default_nettype none

interface pfhc_in_if;
  logic        valid;
  logic        ready;
  logic        operation;
  logic [11:0] load_address;
  logic [7:0]  load_data;
  logic [15:0] stage_opcodes;
  logic [3:0]  execute_load_dest;
  logic [7:0]  decode_sources;
  logic        execute_condition;
  logic        memory_condition;
  logic [63:0] memory_fallthrough;
  logic [63:0] writeback_loaded;

  modport source (
    output valid, operation, load_address, load_data, stage_opcodes,
           execute_load_dest, decode_sources, execute_condition,
           memory_condition, memory_fallthrough, writeback_loaded,
    input  ready
  );

  modport sink (
    input  valid, operation, load_address, load_data, stage_opcodes,
           execute_load_dest, decode_sources, execute_condition,
           memory_condition, memory_fallthrough, writeback_loaded,
    output ready
  );
endinterface

`default_nettype wire

// File: design/pfhc_out_if.sv
// Result channel of the fetch block: valid/ready handshake plus one item.
// Depends on nothing; used by pipelined_fetch_with_hazard_control.
`default_nettype none

interface pfhc_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  fetch_status;
  logic [3:0]  opcode;
  logic [3:0]  function_code;
  logic [3:0]  reg_a;
  logic [3:0]  reg_b;
  logic [63:0] constant_word;
  logic [63:0] next_sequential_pc;
  logic        fetch_stall;
  logic        decode_stall;
  logic        decode_bubble;

  modport source (
    output valid, fetch_status, opcode, function_code, reg_a, reg_b,
           constant_word, next_sequential_pc, fetch_stall, decode_stall,
           decode_bubble,
    input  ready
  );

  modport sink (
    input  valid, fetch_status, opcode, function_code, reg_a, reg_b,
           constant_word, next_sequential_pc, fetch_stall, decode_stall,
           decode_bubble,
    output ready
  );
endinterface

`default_nettype wire

// File: design/pipelined_fetch_with_hazard_control.sv
// Fetch stage of a five-stage Y86-64 pipeline with a byte instruction memory.
// Depends on pfhc_pkg, pfhc_in_if and pfhc_out_if.
//
// After reset the block sweeps the instruction memory to zero, one 16-byte row per
// cycle; ready stays low until that pass ends. The block can take one write item
// every cycle. A fetch item selects its PC on acceptance and reads two adjacent
// 16-byte rows from a two-read-port memory into registers; the registered row data
// is then decoded and the result moves into the output register once that register
// is free. A fetch that advances the predicted PC holds off the next fetch until it
// has left the decode stage, so such fetches do not overlap; behind a fetch that
// reported fetch_stall, back-to-back fetches run at one per cycle while the output
// is not stalled. Writes may be taken while a fetch waits in the decode stage.
`default_nettype none

module pipelined_fetch_with_hazard_control #(
  parameter int MEM_BYTES = pfhc_pkg::MEM_BYTES_DEF
) (
  input  wire        clk_i,
  input  wire        rst_ni,
  pfhc_in_if.sink    in_i,
  pfhc_out_if.source out_o
);
  import pfhc_pkg::*;

  localparam int ROWS = (MEM_BYTES + ROW_BYTES - 1) / ROW_BYTES;
  localparam int AW   = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int PCW  = $clog2(MEM_BYTES) + 1;
  localparam int LAW  = (AW + 4 > 12) ? AW + 4 : 12;

  function automatic logic takes_regs(input logic [3:0] ic);
    logic r;
    case (ic) inside
      OP_RRMOV, OP_ALU, OP_PUSH, OP_POP, OP_IRMOV, OP_RMMOV, OP_MRMOV: r = 1'b1;
      default: r = 1'b0;
    endcase
    return r;
  endfunction

  function automatic logic takes_const(input logic [3:0] ic);
    logic r;
    case (ic) inside
      OP_IRMOV, OP_RMMOV, OP_MRMOV, OP_JUMP, OP_CALL: r = 1'b1;
      default: r = 1'b0;
    endcase
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Control registers
  logic          clr_busy_q;
  logic [AW-1:0] clr_row_q;
  logic          s1_valid_q;
  logic          out_valid_q;
  logic [63:0]   pred_q;

  // Decode-stage payload
  logic [63:0]   pc_q;
  logic          adr_err_q;
  logic          stall_f_q;
  logic          load_use_q;
  logic          bubble_d_q;
  logic [15:0][7:0] rd0_q;
  logic [15:0][7:0] rd1_q;

  // Output payload
  status_e       status_q;
  logic [3:0]    opcode_q;
  logic [3:0]    fun_q;
  logic [3:0]    ra_q;
  logic [3:0]    rb_q;
  logic [63:0]   konst_q;
  logic [63:0]   seq_q;
  logic          ostall_f_q;
  logic          oload_use_q;
  logic          obubble_d_q;

  logic [15:0][7:0] imem [ROWS];

  // ---------------------------------------------------------------------------
  // Accept stage: PC selection, hazard controls, memory read issue
  logic          s1_adv;
  logic          fetch_room;
  logic          in_acc;
  logic          fetch_acc;
  logic          wr_en;
  logic [LAW-1:0] wa_ext;
  logic [AW-1:0] wr_row;
  logic [3:0]    wr_lane;

  logic [3:0]    d_ic, e_ic, m_ic, w_ic;
  logic [3:0]    src_a, src_b;
  logic [63:0]   pc_sel;
  logic          adr_err_s0;
  logic          load_use_s0, ret_pend_s0, stall_f_s0, bubble_d_s0;
  logic [AW-1:0] rd_row0, rd_row1;

  assign s1_adv     = s1_valid_q && (!out_valid_q || out_o.ready);
  // The next fetch needs the predicted PC that the fetch in decode leaves behind.
  assign fetch_room = !s1_valid_q || (s1_adv && stall_f_q);
  assign in_i.ready = !clr_busy_q && ((in_i.operation == OPER_WRITE) || fetch_room);
  assign in_acc     = in_i.valid && in_i.ready;
  assign fetch_acc  = in_acc && (in_i.operation == OPER_FETCH);

  assign wa_ext  = LAW'(in_i.load_address);
  assign wr_row  = wa_ext[AW+3:4];
  assign wr_lane = wa_ext[3:0];
  // one spare bit so that the memory size itself fits in the compare
  assign wr_en   = in_acc && (in_i.operation == OPER_WRITE) &&
                   ({1'b0, wa_ext} < (LAW+1)'(MEM_BYTES));

  always_comb begin
    d_ic  = in_i.stage_opcodes[15:12];
    e_ic  = in_i.stage_opcodes[11:8];
    m_ic  = in_i.stage_opcodes[7:4];
    w_ic  = in_i.stage_opcodes[3:0];
    src_a = in_i.decode_sources[7:4];
    src_b = in_i.decode_sources[3:0];

    if (m_ic == OP_JUMP && !in_i.memory_condition) begin
      pc_sel = in_i.memory_fallthrough;
    end else if (w_ic == OP_RET) begin
      pc_sel = in_i.writeback_loaded;
    end else begin
      pc_sel = pred_q;
    end
    adr_err_s0 = !(pc_sel < 64'(MEM_BYTES));

    load_use_s0 = (e_ic == OP_MRMOV || e_ic == OP_POP) &&
                  (in_i.execute_load_dest == src_a || in_i.execute_load_dest == src_b);
    ret_pend_s0 = (d_ic == OP_RET) || (e_ic == OP_RET) || (m_ic == OP_RET);
    stall_f_s0  = load_use_s0 || ret_pend_s0;
    bubble_d_s0 = (e_ic == OP_JUMP && !in_i.execute_condition) ||
                  (!load_use_s0 && ret_pend_s0);

    // Row holding the first byte and the row after it; the window covers all ten bytes.
    rd_row0 = adr_err_s0 ? '0 : pc_sel[AW+3:4];
    rd_row1 = (rd_row0 == AW'(ROWS - 1)) ? '0 : rd_row0 + 1'b1;
  end

  // ---------------------------------------------------------------------------
  // Instruction memory: clearing pass, byte writes, two registered row reads
  always_ff @(posedge clk_i) begin
    if (clr_busy_q) begin
      imem[clr_row_q] <= '0;
    end else if (wr_en) begin
      imem[wr_row][wr_lane] <= in_i.load_data;
    end
    if (fetch_acc) begin
      rd0_q <= imem[rd_row0];
      rd1_q <= imem[rd_row1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (fetch_acc) begin
      pc_q       <= pc_sel;
      adr_err_q  <= adr_err_s0;
      stall_f_q  <= stall_f_s0;
      load_use_q <= load_use_s0;
      bubble_d_q <= bubble_d_s0;
    end
  end

  // ---------------------------------------------------------------------------
  // Decode stage
  logic [31:0][7:0] win;
  logic [9:0][7:0]  ibytes;
  logic [PCW-1:0]   pc_lo;
  logic [4:0]       bidx;
  logic [3:0]       ic, fn;
  logic             need_r, need_c;
  logic [63:0]      konst, seq, pred;
  logic [3:0]       seq_inc;
  status_e          status;

  always_comb begin
    win   = {rd1_q, rd0_q};
    pc_lo = pc_q[PCW-1:0];
    for (int k = 0; k < 10; k++) begin
      bidx = 5'(pc_q[3:0]) + 5'(k);
      // bytes past the end of memory read as zero
      ibytes[k] = ((pc_lo + PCW'(k)) < PCW'(MEM_BYTES)) ? win[bidx] : 8'h00;
    end

    ic = adr_err_q ? OP_NOP : ibytes[0][7:4];
    fn = adr_err_q ? 4'h0   : ibytes[0][3:0];

    if (adr_err_q) begin
      status = STAT_ADR;
    end else if (ic > OP_POP) begin
      status = STAT_INS;
    end else if (ic == OP_HALT) begin
      status = STAT_HLT;
    end else begin
      status = STAT_AOK;
    end

    need_r = takes_regs(ic);
    need_c = takes_const(ic);
    konst  = need_c ? (need_r ? 64'(ibytes[9:2]) : 64'(ibytes[8:1])) : 64'h0;
    seq_inc = 4'd1 + (need_r ? 4'd1 : 4'd0) + (need_c ? 4'd8 : 4'd0);
    seq     = pc_q + 64'(seq_inc);
    pred    = (ic == OP_JUMP || ic == OP_CALL) ? konst : seq;
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      status_q    <= status;
      opcode_q    <= ic;
      fun_q       <= fn;
      ra_q        <= need_r ? ibytes[1][7:4] : NO_REG;
      rb_q        <= need_r ? ibytes[1][3:0] : NO_REG;
      konst_q     <= konst;
      seq_q       <= seq;
      ostall_f_q  <= stall_f_q;
      oload_use_q <= load_use_q;
      obubble_d_q <= bubble_d_q;
    end
  end

  // ---------------------------------------------------------------------------
  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_busy_q  <= 1'b1;
      clr_row_q   <= '0;
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      pred_q      <= '0;
    end else begin
      if (clr_busy_q) begin
        clr_row_q <= clr_row_q + 1'b1;
        if (clr_row_q == AW'(ROWS - 1)) begin
          clr_busy_q <= 1'b0;
        end
      end

      if (fetch_acc) begin
        s1_valid_q <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_q <= 1'b0;
      end

      if (s1_adv) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end

      if (s1_adv && !stall_f_q) begin
        pred_q <= pred;
      end
    end
  end

  assign out_o.valid              = out_valid_q;
  assign out_o.fetch_status       = status_q;
  assign out_o.opcode             = opcode_q;
  assign out_o.function_code      = fun_q;
  assign out_o.reg_a              = ra_q;
  assign out_o.reg_b              = rb_q;
  assign out_o.constant_word      = konst_q;
  assign out_o.next_sequential_pc = seq_q;
  assign out_o.fetch_stall        = ostall_f_q;
  assign out_o.decode_stall       = oload_use_q;
  assign out_o.decode_bubble      = obubble_d_q;

endmodule

`default_nettype wire

// File: design/pfhc_checker.sv
// Port-level assertions for the fetch block, bound to its top level.
// Depends on pfhc_pkg and pipelined_fetch_with_hazard_control.
`default_nettype none

module pfhc_checker (
  input wire        clk_i,
  input wire        rst_ni,
  input wire        in_valid_i,
  input wire        in_ready_i,
  input wire        in_operation_i,
  input wire        out_valid_i,
  input wire        out_ready_i,
  input wire [1:0]  out_status_i,
  input wire [3:0]  out_opcode_i,
  input wire [63:0] out_konst_i,
  input wire [63:0] out_seq_i,
  input wire        out_stall_f_i
);
  import pfhc_pkg::*;

  logic fetch_acc;
  assign fetch_acc = in_valid_i && in_ready_i && (in_operation_i == OPER_FETCH);

  // The memory clearing pass keeps the input closed right after reset.
  a_clear_after_reset: assert property (@(posedge clk_i)
    disable iff (!rst_ni) $past(!rst_ni) |-> !in_ready_i)
    else $error("input ready during memory clearing pass");

  // A fetch reaches the output when nothing blocks it.
  a_fetch_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fetch_acc ##1 (!out_valid_i || out_ready_i) |=> out_valid_i)
    else $error("fetch item did not reach the output");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result item dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(out_status_i) && $stable(out_opcode_i) &&
      $stable(out_konst_i) && $stable(out_seq_i) && $stable(out_stall_f_i))
    else $error("result item changed while stalled");

endmodule

bind pipelined_fetch_with_hazard_control pfhc_checker u_pfhc_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_i.valid),
  .in_ready_i     (in_i.ready),
  .in_operation_i (in_i.operation),
  .out_valid_i    (out_o.valid),
  .out_ready_i    (out_o.ready),
  .out_status_i   (out_o.fetch_status),
  .out_opcode_i   (out_o.opcode),
  .out_konst_i    (out_o.constant_word),
  .out_seq_i      (out_o.next_sequential_pc),
  .out_stall_f_i  (out_o.fetch_stall)
);

`default_nettype wire
